[hw/rtl/dlrs_pkg.sv]
// Package for the decimal LSD radix sorter: sizes, a digit helper and
// the controller/datapath command enum and struct. No dependencies.
package dlrs_pkg;

  localparam int MaxKeys   = 64;
  localparam int KeyBits   = 32;
  localparam int AddrW     = $clog2(MaxKeys);
  localparam int CountW    = $clog2(MaxKeys + 1);
  localparam int Radix     = 10;
  localparam int MaxDigits = 10;
  localparam int DigitW    = 4;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [DigitW-1:0] digit_t;

  // Quotient of a key by ten, by reciprocal multiply
  // with one correction step.
  function automatic logic [31:0] div10(input logic [31:0] v);
    logic [65:0] p;
    logic [31:0] q;
    logic [35:0] r;
    begin
      p = {34'd0, v} * 66'h0CCCCCCCD;
      q = {1'b0, p[65:35]};
      r = {4'd0, v} - ({4'd0, q} * 36'd10);
      if (r >= 36'd10) q = q + 32'd1;
      div10 = q;
    end
  endfunction

  typedef enum logic [2:0] {
    DpNone  = 3'd0,
    DpStore = 3'd1,
    DpRead  = 3'd2
  } dp_op_e;

  typedef struct packed {
    dp_op_e    op;
    logic      sel_scatter;
    addr_t     addr;
  } dp_cmd_t;

endpackage

[hw/rtl/dlrs_if.sv]
// Valid/ready channel carrying one key and a last flag per beat.
// Depends on nothing.
interface dlrs_if;
  logic        valid;
  logic        ready;
  logic [31:0] key;
  logic        last;
  modport source (output valid, key, last, input ready);
  modport sink   (input valid, key, last, output ready);
endinterface

[hw/rtl/dlrs_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
module dlrs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[hw/rtl/dlrs_digit.sv]
// Digit unit: peels decimal digits off a key, one per cycle.
// Uses dlrs_pkg for the divide-by-ten helper.
module dlrs_digit import dlrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] key_i,
  input  digit_t      pos_i,
  output logic        done_o,
  output digit_t      digit_o,
  output digit_t      ndig_o
);
  logic [31:0] v_q, v_d;
  digit_t      cnt_q, cnt_d, dg_q, dg_d, nd_q, nd_d;
  logic        busy_q, busy_d;
  logic [31:0] q;

  assign q = div10(v_q);

  always_comb begin
    v_d = v_q; cnt_d = cnt_q; dg_d = dg_q; nd_d = nd_q; busy_d = busy_q;
    if (start_i) begin
      v_d = key_i; cnt_d = '0; dg_d = '0; nd_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q == 32'd0) begin
        busy_d = 1'b0;
      end else begin
        if (cnt_q == pos_i) dg_d = digit_t'(v_q - q * 32'd10);
        cnt_d = cnt_q + digit_t'(1);
        nd_d  = nd_q + digit_t'(1);
        v_d   = q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    v_q <= v_d; cnt_q <= cnt_d; dg_q <= dg_d; nd_q <= nd_d;
  end

  assign done_o  = busy_q && (v_q == 32'd0);
  assign digit_o = dg_q;
  assign ndig_o  = nd_q;
endmodule

[hw/rtl/dlrs_datapath.sv]
// Datapath: key and scatter RAMs plus bucket counters and prefix sum.
// Uses dlrs_pkg, dlrs_ram and dlrs_digit.
module dlrs_datapath import dlrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        k_we_i,
  input  addr_t       k_addr_i,
  input  logic [31:0] k_wdata_i,
  output logic [31:0] k_rdata_o,
  input  logic        s_we_i,
  input  addr_t       s_addr_i,
  output logic [31:0] s_rdata_o,
  input  logic        bk_clr_i,
  input  logic        bk_inc_i,
  input  logic        bk_dec_i,
  input  logic        bk_pfx_i,
  input  digit_t      bk_idx_i,
  output count_t      bk_val_o,
  input  logic        dg_start_i,
  input  digit_t      dg_pos_i,
  output logic        dg_done_o,
  output digit_t      dg_digit_o,
  output digit_t      dg_ndig_o
);
  count_t bk_q [Radix];
  count_t dec;

  dlrs_ram #(.Width(32), .Depth(MaxKeys)) u_key (
    .clk_i, .we_i(k_we_i), .addr_i(k_addr_i), .wdata_i(k_wdata_i),
    .rdata_o(k_rdata_o));
  dlrs_ram #(.Width(32), .Depth(MaxKeys)) u_scat (
    .clk_i, .we_i(s_we_i), .addr_i(s_addr_i), .wdata_i(k_rdata_o),
    .rdata_o(s_rdata_o));
  dlrs_digit u_dig (
    .clk_i, .rst_ni, .start_i(dg_start_i), .key_i(k_rdata_o),
    .pos_i(dg_pos_i), .done_o(dg_done_o), .digit_o(dg_digit_o),
    .ndig_o(dg_ndig_o));

  assign dec = bk_q[bk_idx_i] - count_t'(1);
  assign bk_val_o = dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Radix; i++) bk_q[i] <= '0;
    end else if (bk_clr_i) begin
      for (int i = 0; i < Radix; i++) bk_q[i] <= '0;
    end else if (bk_inc_i) begin
      bk_q[bk_idx_i] <= bk_q[bk_idx_i] + count_t'(1);
    end else if (bk_dec_i) begin
      bk_q[bk_idx_i] <= dec;
    end else if (bk_pfx_i) begin
      // One running-sum step per cycle: bucket idx adds in bucket idx-1.
      bk_q[bk_idx_i] <= bk_q[bk_idx_i] + bk_q[bk_idx_i - digit_t'(1)];
    end
  end
endmodule

[hw/rtl/dlrs_ctrl.sv]
// Controller: sequences collect, digit count, passes and emission.
// Uses dlrs_pkg.
module dlrs_ctrl import dlrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output logic        out_last_o,
  input  logic        out_ready_i,
  output logic        out_sel_o,
  output logic        k_we_o,
  output addr_t       k_addr_o,
  output logic        k_src_o,
  output logic        s_we_o,
  output addr_t       s_addr_o,
  output logic        bk_clr_o,
  output logic        bk_inc_o,
  output logic        bk_dec_o,
  output logic        bk_pfx_o,
  output digit_t      bk_idx_o,
  input  count_t      bk_val_i,
  output logic        dg_start_o,
  output digit_t      dg_pos_o,
  input  logic        dg_done_i,
  input  digit_t      dg_digit_i,
  input  digit_t      dg_ndig_i
);
  typedef enum logic [9:0] {
    SCollect = 10'b0000000001,
    SMaxRd   = 10'b0000000010,
    SMaxDg   = 10'b0000000100,
    SCntRd   = 10'b0000001000,
    SCntDg   = 10'b0000010000,
    SPfx     = 10'b0000100000,
    SScRd    = 10'b0001000000,
    SScDg    = 10'b0010000000,
    SCopy    = 10'b0100000000,
    SEmit    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  count_t fill_q, fill_d, i_q, i_d;
  digit_t most_q, most_d, pos_q, pos_d, dig_q, dig_d;
  logic   start_q, start_d, ov_q, ov_d, cp_q, cp_d, ld_q, ld_d;

  assign in_ready_o  = (state_q == SCollect);
  assign dg_start_o  = start_q;
  assign dg_pos_o    = pos_q;
  assign out_valid_o = ov_q;
  assign out_last_o  = ov_q && (i_q == fill_q);
  // High in the first cycle of a beat, while the key RAM read data is it.
  assign out_sel_o   = ld_q;

  always_comb begin
    state_d = state_q; fill_d = fill_q; i_d = i_q; most_d = most_q;
    pos_d = pos_q; dig_d = dig_q; start_d = 1'b0; ov_d = ov_q; cp_d = 1'b0;
    ld_d = 1'b0;
    k_we_o = 1'b0; k_addr_o = i_q[AddrW-1:0]; k_src_o = 1'b0;
    s_we_o = 1'b0; s_addr_o = i_q[AddrW-1:0];
    bk_clr_o = 1'b0; bk_inc_o = 1'b0; bk_dec_o = 1'b0; bk_pfx_o = 1'b0;
    bk_idx_o = dg_digit_i;
    case (state_q)
      SCollect: begin
        k_addr_o = fill_q[AddrW-1:0];
        if (in_valid_i) begin
          if (fill_q < count_t'(MaxKeys)) begin
            k_we_o = 1'b1;
            fill_d = fill_q + count_t'(1);
          end
          if (in_last_i) begin
            i_d = '0; most_d = '0; state_d = SMaxRd;
          end
        end
      end
      SMaxRd: begin
        if (i_q == fill_q) begin
          pos_d = '0; i_d = '0; bk_clr_o = 1'b1;
          state_d = (most_q == '0) ? SEmit : SCntRd;
        end else begin
          start_d = 1'b1; state_d = SMaxDg;
        end
      end
      SMaxDg: begin
        if (start_q) begin
        end else if (dg_done_i) begin
          if (dg_ndig_i > most_q) most_d = dg_ndig_i;
          i_d = i_q + count_t'(1); state_d = SMaxRd;
        end
      end
      SCntRd: begin
        if (i_q == fill_q) begin
          dig_d = digit_t'(1); state_d = SPfx;
        end else begin
          start_d = 1'b1; state_d = SCntDg;
        end
      end
      SCntDg: begin
        if (!start_q && dg_done_i) begin
          bk_inc_o = 1'b1;
          i_d = i_q + count_t'(1); state_d = SCntRd;
        end
      end
      SPfx: begin
        bk_pfx_o = 1'b1; bk_idx_o = dig_q;
        if (dig_q == digit_t'(Radix - 1)) state_d = SScRd;
        dig_d = dig_q + digit_t'(1);
        i_d = fill_q;
      end
      SScRd: begin
        if (i_q == '0) begin
          state_d = SCopy;
        end else begin
          k_addr_o = AddrW'(i_q - count_t'(1));
          start_d = 1'b1; state_d = SScDg;
        end
      end
      SScDg: begin
        k_addr_o = AddrW'(i_q - count_t'(1));
        if (!start_q && dg_done_i) begin
          bk_dec_o = 1'b1;
          s_we_o = 1'b1; s_addr_o = bk_val_i[AddrW-1:0];
          i_d = i_q - count_t'(1); state_d = SScRd;
        end
      end
      SCopy: begin
        // Read scatter[i], write key[i] in the following cycle.
        s_addr_o = i_q[AddrW-1:0];
        cp_d = (i_q < fill_q);
        if (cp_q) begin
          k_we_o = 1'b1; k_src_o = 1'b1;
          k_addr_o = AddrW'(i_q - count_t'(1));
        end
        if (i_q < fill_q) i_d = i_q + count_t'(1);
        else if (!cp_q) begin
          i_d = '0; bk_clr_o = 1'b1; pos_d = pos_q + digit_t'(1);
          state_d = (pos_q + digit_t'(1) == most_q) ? SEmit : SCntRd;
        end
      end
      SEmit: begin
        // i_q holds the number of beats already loaded into the output.
        if (!ov_q || out_ready_i) begin
          if (i_q == fill_q) begin
            ov_d = 1'b0;
            if (!ov_q || out_ready_i) begin
              fill_d = '0; i_d = '0; state_d = SCollect;
            end
          end else begin
            ov_d = 1'b1; ld_d = 1'b1; i_d = i_q + count_t'(1);
          end
        end
      end
      default: state_d = SCollect;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCollect; fill_q <= '0; i_q <= '0; most_q <= '0;
      pos_q <= '0; dig_q <= '0; start_q <= 1'b0; ov_q <= 1'b0; cp_q <= 1'b0;
      ld_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; i_q <= i_d; most_q <= most_d;
      pos_q <= pos_d; dig_q <= dig_d; start_q <= start_d; ov_q <= ov_d;
      cp_q <= cp_d; ld_q <= ld_d;
    end
  end
endmodule

[hw/rtl/decimal_lsd_radix_sorter_top.sv]
// Decimal LSD radix sorter: collects up to 64 unsigned keys per set on
// in_ch and, after a beat with last set, sorts them ascending by
// repeated stable counting sorts on decimal digits, least significant
// first, then sends them on out_ch with last on the final beat.
// Input: one beat per cycle while collecting; ready is low from the
// last beat until the sorted set has been fully sent. Keys beyond 64
// in a set are dropped.
// Sorting: a scan for the largest digit count, then per digit pass a
// count scan, a prefix sum, a scatter and a copy back. Each key visit
// starts the digit unit, which strips one decimal digit per cycle.
// Output: one beat per cycle; a stall holds the beat and pauses the
// sender. Reset empties the store and drops any set in progress.
// Depends on dlrs_pkg, dlrs_if, dlrs_ram, dlrs_digit, dlrs_datapath,
// dlrs_ctrl.
module decimal_lsd_radix_sorter_top import dlrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dlrs_if.sink   in_ch,
  dlrs_if.source out_ch
);
  logic        k_we, k_src, s_we, bk_clr, bk_inc, bk_dec, bk_pfx;
  logic        dg_start, dg_done, ov, ol, out_sel;
  addr_t       k_addr, s_addr;
  digit_t      bk_idx, dg_pos, dg_digit, dg_ndig;
  count_t      bk_val;
  logic [31:0] k_rdata, s_rdata, k_wdata, data_q;

  dlrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_last_i(in_ch.last), .in_ready_o(in_ch.ready),
    .out_valid_o(ov), .out_last_o(ol), .out_ready_i(out_ch.ready),
    .out_sel_o(out_sel),
    .k_we_o(k_we), .k_addr_o(k_addr), .k_src_o(k_src),
    .s_we_o(s_we), .s_addr_o(s_addr),
    .bk_clr_o(bk_clr), .bk_inc_o(bk_inc), .bk_dec_o(bk_dec), .bk_pfx_o(bk_pfx),
    .bk_idx_o(bk_idx), .bk_val_i(bk_val),
    .dg_start_o(dg_start), .dg_pos_o(dg_pos), .dg_done_i(dg_done),
    .dg_digit_i(dg_digit), .dg_ndig_i(dg_ndig));

  assign k_wdata = k_src ? s_rdata : in_ch.key;

  dlrs_datapath u_dp (
    .clk_i, .rst_ni,
    .k_we_i(k_we), .k_addr_i(k_addr), .k_wdata_i(k_wdata), .k_rdata_o(k_rdata),
    .s_we_i(s_we), .s_addr_i(s_addr), .s_rdata_o(s_rdata),
    .bk_clr_i(bk_clr), .bk_inc_i(bk_inc), .bk_dec_i(bk_dec), .bk_pfx_i(bk_pfx),
    .bk_idx_i(bk_idx), .bk_val_o(bk_val),
    .dg_start_i(dg_start), .dg_pos_i(dg_pos), .dg_done_o(dg_done),
    .dg_digit_o(dg_digit), .dg_ndig_o(dg_ndig));

  // Key RAM read data is the current beat only in its first cycle, since the
  // controller already addresses the next key; hold it for stalled cycles.
  always_ff @(posedge clk_i) begin
    if (out_sel) data_q <= k_rdata;
  end

  assign out_ch.valid = ov;
  assign out_ch.last  = ol;
  assign out_ch.key   = out_sel ? k_rdata : data_q;
endmodule

[bench/tb_dlrs_checker.sv]
// Checker for the decimal LSD radix sorter: watches both channels, predicts
// the sorted sets and compares every output beat. Depends on dlrs_pkg, dlrs_if.
module tb_dlrs_checker import dlrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dlrs_if      in_mon,
  dlrs_if      out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [31:0] sorted_key;
    logic        last_out;
  } sorted_beat_t;

  logic [31:0]  set_keys[$];
  sorted_beat_t sorted_q[$];
  int           fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = sorted_q.size();

  function automatic int decimal_digits(logic [31:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v / 10;
    end
    return n;
  endfunction

  function automatic int digit_at(logic [31:0] v, int pos);
    logic [31:0] p;
    p = 1;
    for (int i = 0; i < pos; i++) p = p * 10;
    return (v / p) % 10;
  endfunction

  // Stable counting sort per decimal digit, least significant first.
  task automatic sort_set();
    logic [31:0] work[$];
    logic [31:0] spill[];
    int          buckets[10];
    int          most, n, d;
    work = set_keys;
    n    = work.size();
    most = 0;
    foreach (work[i]) if (decimal_digits(work[i]) > most) most = decimal_digits(work[i]);
    spill = new[n];
    for (int pos = 0; pos < most; pos++) begin
      foreach (buckets[b]) buckets[b] = 0;
      foreach (work[i]) buckets[digit_at(work[i], pos)]++;
      for (int b = 1; b < 10; b++) buckets[b] += buckets[b-1];
      for (int i = n - 1; i >= 0; i--) begin
        d = digit_at(work[i], pos);
        buckets[d]--;
        spill[buckets[d]] = work[i];
      end
      foreach (work[i]) work[i] = spill[i];
    end
    foreach (work[i]) sorted_q.push_back('{work[i], (i == n - 1)});
    set_keys.delete();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count <= 0;
      set_keys.delete();
      sorted_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected beat key=%0d last=%0b", $time, out_mon.key,
                   out_mon.last);
          fail_count <= fail_count + 1;
        end else begin
          if (sorted_q[0].sorted_key !== out_mon.key ||
              sorted_q[0].last_out !== out_mon.last) begin
            $display("%0t: mismatch expected key=%0d last=%0b actual key=%0d last=%0b",
                     $time, sorted_q[0].sorted_key, sorted_q[0].last_out,
                     out_mon.key, out_mon.last);
            fail_count <= fail_count + 1;
          end
          void'(sorted_q.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (set_keys.size() < MaxKeys) set_keys.push_back(in_mon.key);
        if (in_mon.last) sort_set();
      end
    end
  end

endmodule

[bench/tb_decimal_lsd_radix_sorter_top.sv]
// Testbench top for the decimal LSD radix sorter: drives key sets with random
// idling and stalls, and gives the verdict. Depends on dlrs_pkg, dlrs_if,
// tb_dlrs_checker and the RTL.
module tb_decimal_lsd_radix_sorter_top import dlrs_pkg::*;;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   send_idle, recv_stall;

  dlrs_if in_ch();
  dlrs_if out_ch();

  always #5 clk_i = ~clk_i;

  decimal_lsd_radix_sorter_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tb_dlrs_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.key    = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    send_idle    = 0;
    recv_stall   = 0;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Sends one beat, holding it until it is accepted.
  task automatic send_key(logic [31:0] k, logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.key   <= k;
    in_ch.last  <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom_range(9);
      2: return $urandom_range(999);
      3: return $urandom_range(99999);
      4: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_key(rand_key(), i == n - 1);
  endtask

  // Stops sending and waits until every expected beat has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: single key, all zeros, extremes with ties, full store plus drops.
    send_key(32'd0, 1'b1);
    send_key(32'hFFFF_FFFF, 1'b0);
    send_key(32'd0, 1'b0);
    send_key(32'd1000000000, 1'b0);
    send_key(32'd9, 1'b0);
    send_key(32'd9, 1'b0);
    send_key(32'h5555_5555, 1'b0);
    send_key(32'hAAAA_AAAA, 1'b1);
    send_key(32'd0, 1'b0);
    send_key(32'd0, 1'b1);
    drain();
    for (int i = 0; i < 66; i++) send_key(32'd70 - i, i == 65);
    drain();
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? 73 : 0;
      recv_stall = (ph == 2) ? 73 : (ph == 3 ? 15 : 0);
      if (ph == 3) send_idle = 15;
      while (sent < (ph + 1) * 96) begin
        int n;
        n = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 12);
        send_set(n);
        sent += n;
      end
      drain();
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/dlrs_pkg.sv
hw/rtl/dlrs_if.sv
hw/rtl/dlrs_ram.sv
hw/rtl/dlrs_digit.sv
hw/rtl/dlrs_datapath.sv
hw/rtl/dlrs_ctrl.sv
hw/rtl/decimal_lsd_radix_sorter_top.sv
bench/tb_dlrs_checker.sv
bench/tb_decimal_lsd_radix_sorter_top.sv
